// ===== rtl/hcf_pkg.sv =====
package hcf_pkg;

  localparam int HCF_GRID_WIDTH  = 512;
  localparam int HCF_GRID_HEIGHT = 512;
  localparam int HCF_HEIGHT_BITS = 16;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_JUMP      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_ALPHA   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTLIER_TOL   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTLIER_ALPHA = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_COUNT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONF_CAP      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONF_THRESH   = 3'd6;

  localparam logic [15:0] RST_MAX_JUMP      = 16'd350;
  localparam logic [8:0]  RST_BLEND_ALPHA   = 9'd51;
  localparam logic [15:0] RST_OUTLIER_TOL   = 16'd150;
  localparam logic [8:0]  RST_OUTLIER_ALPHA = 9'd51;
  localparam logic [3:0]  RST_ACCEPT_COUNT  = 4'd4;
  localparam logic [7:0]  RST_CONF_CAP      = 8'd20;
  localparam logic [7:0]  RST_CONF_THRESH   = 8'd2;

  localparam logic [8:0] TRACK_NEW_W = 9'd51;
  localparam logic [8:0] ALPHA_FULL  = 9'd256;
  localparam logic [3:0] COUNT_MAX   = 4'd15;

  typedef enum logic [2:0] {
    OUT_INIT      = 3'd0,
    OUT_SMOOTHED  = 3'd1,
    OUT_STARTED   = 3'd2,
    OUT_COUNTED   = 3'd3,
    OUT_ACCEPTED  = 3'd4,
    OUT_RESTARTED = 3'd5
  } outcome_t;

endpackage

// ===== rtl/height_cell_fusion_with_outlier_confirm_unit.sv =====
// per-cell height fusion with outlier confirmation
//
// input: a beat is taken on a rising edge with start high and busy low. it
// carries a grid cell (in_grid_x, in_grid_y) and a signed height in mm.
// a cell outside the grid is dropped: no state change and no result.
// result: out_valid is high for exactly one cycle with the fused height,
// confidence, outcome code, pending outlier count and confident flag. the
// receiver cannot stall; the result must be taken in that cycle.
// sequence: the cell is read at accept, evaluated in ST_EVAL (jump tests,
// blend and track products), then ST_MIX does the confirmed-outlier blend,
// write-back and result; busy is high in both states, so a new beat is
// taken only once the last one is through.
// configuration: cfg_we writes register cfg_index at any edge, meant to be
// used while the block is idle; there is no read-back.
// reset: synchronous on rst_n low. registers take their reset values and a
// clearing pass then writes every cell, one per cycle, with busy held high
// throughout.
module height_cell_fusion_with_outlier_confirm_unit
  import hcf_pkg::*;
#(
  parameter int GRID_WIDTH  = HCF_GRID_WIDTH,
  parameter int GRID_HEIGHT = HCF_GRID_HEIGHT,
  parameter int HEIGHT_BITS = HCF_HEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [8:0]             in_grid_x,
  input  logic [8:0]             in_grid_y,
  input  logic signed [15:0]     in_measured_height,
  output logic                   out_valid,
  output logic signed [15:0]     out_fused_height,
  output logic [7:0]             out_confidence_out,
  output logic [2:0]             out_outcome,
  output logic [3:0]             out_pending_count,
  output logic                   out_is_confident,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int CW    = $clog2(CELLS);
  localparam int HB    = HEIGHT_BITS;
  localparam int DW    = HB + 1;
  localparam int SW    = HB + 11;
  localparam logic signed [33:0] HMAX = (34'sd1 <<< (HB - 1)) - 34'sd1;
  localparam logic signed [33:0] HMIN = -HMAX - 34'sd1;

  typedef struct packed {
    logic                 known;
    logic                 pend;
    logic signed [HB-1:0] h;
    logic [7:0]           conf;
    logic signed [HB-1:0] oh;
    logic [3:0]           cnt;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_MIX   = 4'b1000
  } state_t;

  function automatic logic signed [HB-1:0] mix_f(input logic signed [HB-1:0] old_v,
                                                 input logic signed [HB-1:0] new_v,
                                                 input logic [8:0] w);
    logic signed [DW-1:0] d;
    logic signed [SW-1:0] s;
    d = DW'(new_v) - DW'(old_v);
    s = (SW'(old_v) <<< 8) + SW'(d) * SW'(signed'({1'b0, w})) + SW'(128);
    return HB'(s >>> 8);
  endfunction

  function automatic logic [DW-1:0] absdiff_f(input logic signed [HB-1:0] a,
                                              input logic signed [HB-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return (d < 0) ? DW'(-d) : DW'(d);
  endfunction

  function automatic logic [7:0] bump_f(input logic [7:0] c, input logic [7:0] cap);
    logic [8:0] n;
    n = {1'b0, c} + 9'd1;
    return (n < {1'b0, cap}) ? n[7:0] : cap;
  endfunction

  // configuration
  logic [15:0] max_jump_r;
  logic [8:0]  blend_alpha_r;
  logic [15:0] outlier_tol_r;
  logic [8:0]  merge_alpha_r;
  logic [3:0]  accept_count_r;
  logic [7:0]  conf_cap_r;
  logic [7:0]  conf_thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_jump_r      <= RST_MAX_JUMP;
      blend_alpha_r   <= RST_BLEND_ALPHA;
      outlier_tol_r   <= RST_OUTLIER_TOL;
      merge_alpha_r   <= RST_OUTLIER_ALPHA;
      accept_count_r  <= RST_ACCEPT_COUNT;
      conf_cap_r      <= RST_CONF_CAP;
      conf_thresh_r   <= RST_CONF_THRESH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_JUMP:      max_jump_r      <= cfg_wdata;
        CFG_BLEND_ALPHA:   blend_alpha_r   <= cfg_wdata[8:0];
        CFG_OUTLIER_TOL:   outlier_tol_r   <= cfg_wdata;
        CFG_OUTLIER_ALPHA: merge_alpha_r   <= cfg_wdata[8:0];
        CFG_ACCEPT_COUNT:  accept_count_r  <= cfg_wdata[3:0];
        CFG_CONF_CAP:      conf_cap_r      <= cfg_wdata[7:0];
        CFG_CONF_THRESH:   conf_thresh_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic [8:0] blend_w;
  logic [8:0] outlier_w;
  assign blend_w   = blend_alpha_r[8]   ? ALPHA_FULL : blend_alpha_r;
  assign outlier_w = merge_alpha_r[8]   ? ALPHA_FULL : merge_alpha_r;

  // control
  state_t         state_r, state_nxt;
  logic [CW-1:0]  clr_cnt_r;
  logic           accept;
  logic           in_grid;
  logic [CW-1:0]  in_cell;
  logic signed [33:0]   m_ext;
  logic signed [HB-1:0] m_sat;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign in_grid = (32'(in_grid_x) < 32'(GRID_WIDTH)) && (32'(in_grid_y) < 32'(GRID_HEIGHT));
  assign in_cell = CW'(32'(in_grid_y) * 32'(GRID_WIDTH) + 32'(in_grid_x));

  always_comb begin
    m_ext = 34'(in_measured_height);
    if (m_ext > HMAX) begin
      m_sat = HB'(HMAX);
    end else if (m_ext < HMIN) begin
      m_sat = HB'(HMIN);
    end else begin
      m_sat = HB'(m_ext);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == CW'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept && in_grid) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + CW'(1);
    end
  end

  // cell memory
  entry_t         mem [CELLS];
  entry_t         rd_r;
  entry_t         wr_entry;
  logic           mem_we;
  logic [CW-1:0]  mem_waddr;
  entry_t         mem_wdata;

  logic [CW-1:0]        cell_r;
  logic signed [HB-1:0] m_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_r;
    mem_wdata = wr_entry;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == ST_MIX) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[in_cell];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_r <= in_cell;
      m_r    <= m_sat;
    end
  end

  // evaluate: jump tests, normal blend and track update
  outcome_t             ev_outcome_r, ev_outcome;
  entry_t               ev_entry_r;
  logic signed [HB-1:0] ev_blend_r;
  logic signed [HB-1:0] ev_track_r;
  logic [3:0]           ev_cnt_r, cnt_inc;
  logic [DW-1:0]        jump_abs, track_abs;

  assign jump_abs  = absdiff_f(m_r, rd_r.h);
  assign track_abs = absdiff_f(m_r, rd_r.oh);
  assign cnt_inc   = (rd_r.cnt == COUNT_MAX) ? COUNT_MAX : rd_r.cnt + 4'd1;

  always_comb begin
    if (!rd_r.known) begin
      ev_outcome = OUT_INIT;
    end else if (33'(jump_abs) <= 33'(max_jump_r)) begin
      ev_outcome = OUT_SMOOTHED;
    end else if (!rd_r.pend) begin
      ev_outcome = OUT_STARTED;
    end else if (33'(track_abs) <= 33'(outlier_tol_r)) begin
      ev_outcome = (cnt_inc >= accept_count_r) ? OUT_ACCEPTED : OUT_COUNTED;
    end else begin
      ev_outcome = OUT_RESTARTED;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      ev_outcome_r <= ev_outcome;
      ev_entry_r   <= rd_r;
      ev_blend_r   <= mix_f(rd_r.h, m_r, blend_w);
      ev_track_r   <= mix_f(rd_r.oh, m_r, TRACK_NEW_W);
      ev_cnt_r     <= cnt_inc;
    end
  end

  // merge and write-back
  always_comb begin
    wr_entry = ev_entry_r;
    case (ev_outcome_r)
      OUT_INIT: begin
        wr_entry.known = 1'b1;
        wr_entry.h     = m_r;
        wr_entry.conf  = 8'd1;
        wr_entry.pend  = 1'b0;
        wr_entry.cnt   = 4'd0;
      end
      OUT_SMOOTHED: begin
        wr_entry.h    = ev_blend_r;
        wr_entry.conf = bump_f(ev_entry_r.conf, conf_cap_r);
        wr_entry.pend = 1'b0;
        wr_entry.cnt  = 4'd0;
      end
      OUT_STARTED: begin
        wr_entry.pend = 1'b1;
        wr_entry.oh   = m_r;
        wr_entry.cnt  = 4'd1;
      end
      OUT_COUNTED: begin
        wr_entry.oh  = ev_track_r;
        wr_entry.cnt = ev_cnt_r;
      end
      OUT_ACCEPTED: begin
        wr_entry.h    = mix_f(ev_entry_r.h, ev_track_r, outlier_w);
        wr_entry.conf = bump_f(ev_entry_r.conf, conf_cap_r);
        wr_entry.pend = 1'b0;
        wr_entry.cnt  = 4'd0;
      end
      OUT_RESTARTED: begin
        wr_entry.oh  = m_r;
        wr_entry.cnt = 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == ST_MIX);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MIX) begin
      out_fused_height   <= 16'(wr_entry.h);
      out_confidence_out <= wr_entry.conf;
      out_outcome        <= ev_outcome_r;
      out_pending_count  <= wr_entry.pend ? wr_entry.cnt : 4'd0;
      out_is_confident   <= (wr_entry.conf >= conf_thresh_r);
    end
  end

endmodule

// ===== rtl/hcf_checker.sv =====
module hcf_checker
  import hcf_pkg::*;
#(
  parameter int GRID_WIDTH  = HCF_GRID_WIDTH,
  parameter int GRID_HEIGHT = HCF_GRID_HEIGHT
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic [8:0]             in_grid_x,
  input logic [8:0]             in_grid_y,
  input logic                   out_valid,
  input logic [7:0]             out_confidence_out,
  input logic [2:0]             out_outcome,
  input logic [3:0]             out_pending_count
);

  logic in_grid;
  assign in_grid = (32'(in_grid_x) < 32'(GRID_WIDTH)) && (32'(in_grid_y) < 32'(GRID_HEIGHT));

  // an in-grid beat gives its result once it has passed ST_EVAL and ST_MIX
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_grid) |-> ##3 out_valid)
    else $error("result missing after accepted beat");

  // a dropped cell gives no work
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_grid) |=> !busy)
    else $error("out-of-grid beat started work");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a fresh cell has unit confidence and no track
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == OUT_INIT) |->
      (out_confidence_out == 8'd1 && out_pending_count == 4'd0))
    else $error("init result malformed");

  // only an open track reports a pending count
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pending_count != 4'd0) |->
      (out_outcome == OUT_STARTED || out_outcome == OUT_COUNTED ||
       out_outcome == OUT_RESTARTED))
    else $error("pending count without open track");

endmodule

bind height_cell_fusion_with_outlier_confirm_unit hcf_checker #(
  .GRID_WIDTH(GRID_WIDTH),
  .GRID_HEIGHT(GRID_HEIGHT)
) u_hcf_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_grid_x(in_grid_x),
  .in_grid_y(in_grid_y),
  .out_valid(out_valid),
  .out_confidence_out(out_confidence_out),
  .out_outcome(out_outcome),
  .out_pending_count(out_pending_count)
);

// ===== tb/testbench.sv =====
import hcf_pkg::*;

typedef struct packed {
  logic signed [15:0] height;
  logic [7:0]         conf;
  outcome_t           outcome;
  logic [3:0]         pend;
  logic               confident;
} fusion_result_t;

class fusion_scoreboard;
  logic [15:0] max_jump;
  logic [8:0]  blend_alpha;
  logic [15:0] outlier_tol;
  logic [8:0]  merge_alpha;
  logic [3:0]  accept_cnt;
  logic [7:0]  conf_cap;
  logic [7:0]  conf_thresh;

  bit              known     [HCF_GRID_WIDTH*HCF_GRID_HEIGHT];
  bit signed [15:0] height_mem[HCF_GRID_WIDTH*HCF_GRID_HEIGHT];
  bit [7:0]        conf_mem  [HCF_GRID_WIDTH*HCF_GRID_HEIGHT];
  bit signed [15:0] track_mem [HCF_GRID_WIDTH*HCF_GRID_HEIGHT];
  bit [3:0]        count_mem [HCF_GRID_WIDTH*HCF_GRID_HEIGHT];
  bit              pend_flag [HCF_GRID_WIDTH*HCF_GRID_HEIGHT];

  fusion_result_t due[$];
  int errors;
  int checked;
  int outcome_tally[6];

  function new();
    max_jump      = RST_MAX_JUMP;
    blend_alpha   = RST_BLEND_ALPHA;
    outlier_tol   = RST_OUTLIER_TOL;
    merge_alpha   = RST_OUTLIER_ALPHA;
    accept_cnt    = RST_ACCEPT_COUNT;
    conf_cap      = RST_CONF_CAP;
    conf_thresh   = RST_CONF_THRESH;
    errors  = 0;
    checked = 0;
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MAX_JUMP:      max_jump      = val;
      CFG_BLEND_ALPHA:   blend_alpha   = val[8:0];
      CFG_OUTLIER_TOL:   outlier_tol   = val;
      CFG_OUTLIER_ALPHA: merge_alpha   = val[8:0];
      CFG_ACCEPT_COUNT:  accept_cnt    = val[3:0];
      CFG_CONF_CAP:      conf_cap      = val[7:0];
      CFG_CONF_THRESH:   conf_thresh   = val[7:0];
      default: ;
    endcase
  endfunction

  function longint height_gap(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // rounded half up, weights clipped to full scale
  function longint blend(longint old_v, longint new_v, logic [8:0] w);
    longint wn;
    wn = (w > ALPHA_FULL) ? longint'(ALPHA_FULL) : longint'(w);
    return ((longint'(ALPHA_FULL) - wn) * old_v + wn * new_v + 128) >>> 8;
  endfunction

  function logic [7:0] bump(logic [7:0] c);
    int n;
    n = int'(c) + 1;
    return (n < int'(conf_cap)) ? n[7:0] : conf_cap;
  endfunction

  function void note_sample(logic [8:0] gx, logic [8:0] gy, logic signed [15:0] mh);
    int slot;
    int cnt;
    longint m, old_h, prev, trk;
    outcome_t oc;
    fusion_result_t r;
    if (gx >= HCF_GRID_WIDTH || gy >= HCF_GRID_HEIGHT) return;
    slot = int'(gy) * HCF_GRID_WIDTH + int'(gx);
    m = mh;
    if (!known[slot]) begin
      known[slot]      = 1'b1;
      height_mem[slot] = mh;
      conf_mem[slot]   = 8'd1;
      pend_flag[slot]  = 1'b0;
      count_mem[slot]  = 4'd0;
      oc = OUT_INIT;
    end else begin
      old_h = height_mem[slot];
      if (height_gap(m, old_h) <= longint'(max_jump)) begin
        height_mem[slot] = 16'(blend(old_h, m, blend_alpha));
        conf_mem[slot]   = bump(conf_mem[slot]);
        pend_flag[slot]  = 1'b0;
        count_mem[slot]  = 4'd0;
        oc = OUT_SMOOTHED;
      end else if (!pend_flag[slot]) begin
        pend_flag[slot] = 1'b1;
        track_mem[slot] = mh;
        count_mem[slot] = 4'd1;
        oc = OUT_STARTED;
      end else begin
        prev = track_mem[slot];
        if (height_gap(m, prev) <= longint'(outlier_tol)) begin
          cnt = int'(count_mem[slot]) + 1;
          if (cnt > int'(COUNT_MAX)) cnt = int'(COUNT_MAX);
          trk = ((longint'(ALPHA_FULL) - longint'(TRACK_NEW_W)) * prev
                 + longint'(TRACK_NEW_W) * m + 128) >>> 8;
          if (cnt >= int'(accept_cnt)) begin
            height_mem[slot] = 16'(blend(old_h, trk, merge_alpha));
            conf_mem[slot]   = bump(conf_mem[slot]);
            pend_flag[slot]  = 1'b0;
            count_mem[slot]  = 4'd0;
            oc = OUT_ACCEPTED;
          end else begin
            track_mem[slot] = 16'(trk);
            count_mem[slot] = cnt[3:0];
            oc = OUT_COUNTED;
          end
        end else begin
          track_mem[slot] = mh;
          count_mem[slot] = 4'd1;
          oc = OUT_RESTARTED;
        end
      end
    end
    r.height    = height_mem[slot];
    r.conf      = conf_mem[slot];
    r.outcome   = oc;
    r.pend      = pend_flag[slot] ? count_mem[slot] : 4'd0;
    r.confident = (conf_mem[slot] >= conf_thresh);
    due = {due, r};
  endfunction

  function void check_result(fusion_result_t got);
    fusion_result_t exp_r;
    if (due.size() == 0) begin
      $error("result beat with no sample waiting");
      errors++;
      return;
    end
    exp_r = due.pop_front();
    checked++;
    outcome_tally[int'(exp_r.outcome)]++;
    if (got.height !== exp_r.height) begin
      $error("fused_height: expected %0d, got %0d", exp_r.height, got.height);
      errors++;
    end
    if (got.conf !== exp_r.conf) begin
      $error("confidence_out: expected %0d, got %0d", exp_r.conf, got.conf);
      errors++;
    end
    if (got.outcome !== exp_r.outcome) begin
      $error("outcome: expected %0d, got %0d", exp_r.outcome, got.outcome);
      errors++;
    end
    if (got.pend !== exp_r.pend) begin
      $error("pending_count: expected %0d, got %0d", exp_r.pend, got.pend);
      errors++;
    end
    if (got.confident !== exp_r.confident) begin
      $error("is_confident: expected %0d, got %0d", exp_r.confident, got.confident);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int CELLS = HCF_GRID_WIDTH * HCF_GRID_HEIGHT;
  localparam int unsigned STALL_LIMIT = 800000;
  localparam int BEATS_PER_SETTING = 78;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic [8:0]             in_grid_x = '0;
  logic [8:0]             in_grid_y = '0;
  logic signed [15:0]     in_measured_height = '0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic                   busy;
  logic                   out_valid;
  logic signed [15:0]     out_fused_height;
  logic [7:0]             out_confidence_out;
  logic [2:0]             out_outcome;
  logic [3:0]             out_pending_count;
  logic                   out_is_confident;

  fusion_scoreboard sb;
  fusion_result_t   seen;
  int               cell_pool[16];
  int               pool_span = 3;
  bit               gaps_on = 1'b1;
  int               beats_sent = 0;
  int               settings_used = 0;
  int unsigned      quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  height_cell_fusion_with_outlier_confirm_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_grid_x          (in_grid_x),
    .in_grid_y          (in_grid_y),
    .in_measured_height (in_measured_height),
    .out_valid          (out_valid),
    .out_fused_height   (out_fused_height),
    .out_confidence_out (out_confidence_out),
    .out_outcome        (out_outcome),
    .out_pending_count  (out_pending_count),
    .out_is_confident   (out_is_confident),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      seen.height    = out_fused_height;
      seen.conf      = out_confidence_out;
      seen.outcome   = outcome_t'(out_outcome);
      seen.pend      = out_pending_count;
      seen.confident = out_is_confident;
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_height(int h);
    return (h > 32767) ? 32767 : ((h < -32768) ? -32768 : h);
  endfunction

  function automatic int jump_height(int slot);
    int off;
    off = int'(sb.max_jump) + 1 + int'($urandom_range(0, 400));
    if ($urandom_range(0, 1)) off = -off;
    return clamp_height(int'(sb.height_mem[slot]) + off);
  endfunction

  function automatic int track_height(int slot);
    int lim, off;
    lim = (sb.outlier_tol > 3000) ? 3000 : int'(sb.outlier_tol);
    off = int'($urandom_range(0, 2 * lim)) - lim;
    return clamp_height(int'(sb.track_mem[slot]) + off);
  endfunction

  function automatic int pick_height(int slot);
    int sel, lim, off;
    sel = $urandom_range(0, 99);
    if (!sb.known[slot] || sel < 12) return int'($urandom_range(0, 65535)) - 32768;
    if (sel < 16) return $urandom_range(0, 1) ? 32767 : -32768;
    if (sel < 45) begin
      lim = (sb.max_jump > 3000) ? 3000 : int'(sb.max_jump);
      off = int'($urandom_range(0, 2 * lim)) - lim;
      return clamp_height(int'(sb.height_mem[slot]) + off);
    end
    if (sel < 85 && sb.pend_flag[slot]) return track_height(slot);
    return jump_height(slot);
  endfunction

  function automatic int gap_len();
    int sel;
    if (!gaps_on) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic [8:0] gx, input logic [8:0] gy,
                           input logic signed [15:0] h);
    start              <= 1'b1;
    in_grid_x          <= gx;
    in_grid_y          <= gy;
    in_measured_height <= h;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_sample(gx, gy, h);
    beats_sent++;
  endtask

  // fields wander while idle so the block must ignore them
  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) begin
        in_grid_x          <= 9'($urandom);
        in_grid_y          <= 9'($urandom);
        in_measured_height <= 16'($urandom);
        @(posedge clk);
      end
    end
  endtask

  task automatic beat(input int slot, input int h);
    logic signed [15:0] hv;
    hv = h[15:0];
    idle_for(gap_len());
    send_beat(9'(slot % HCF_GRID_WIDTH), 9'(slot / HCF_GRID_WIDTH), hv);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [15:0] mj, input logic [15:0] ba,
                                input logic [15:0] ot, input logic [15:0] oa,
                                input logic [15:0] ac, input logic [15:0] cc,
                                input logic [15:0] ct);
    write_reg(CFG_MAX_JUMP, mj);
    write_reg(CFG_BLEND_ALPHA, ba);
    write_reg(CFG_OUTLIER_TOL, ot);
    write_reg(CFG_OUTLIER_ALPHA, oa);
    write_reg(CFG_ACCEPT_COUNT, ac);
    write_reg(CFG_CONF_CAP, cc);
    write_reg(CFG_CONF_THRESH, ct);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly coherent per-cell sequences, with runs that push a track to acceptance
  task automatic run_random(input int count);
    int stop_at, slot, n;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 99) < 88) slot = cell_pool[$urandom_range(0, pool_span - 1)];
      else slot = $urandom_range(0, CELLS - 1);
      if (sb.known[slot] && $urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, int'(sb.accept_cnt) + 1);
        repeat (n + 1) begin
          if (sb.pend_flag[slot]) beat(slot, track_height(slot));
          else beat(slot, jump_height(slot));
        end
      end else begin
        beat(slot, pick_height(slot));
      end
    end
  endtask

  initial begin
    sb = new();
    cell_pool[0] = 0;
    cell_pool[1] = CELLS - 1;
    cell_pool[2] = 9'h0AA * HCF_GRID_WIDTH + 9'h155;
    cell_pool[3] = 9'h155 * HCF_GRID_WIDTH + 9'h0AA;
    for (int i = 4; i < 16; i++) cell_pool[i] = $urandom_range(0, CELLS - 1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // reset settings: height extremes, jump and tolerance boundaries
    beat(cell_pool[0], 32767);
    beat(cell_pool[0], 32767);
    beat(cell_pool[0], 32417);
    beat(cell_pool[0], -32768);
    beat(cell_pool[0], -32768);
    beat(cell_pool[0], -32618);
    beat(cell_pool[0], -32700);
    beat(cell_pool[0], 0);
    beat(cell_pool[0], 10000);
    beat(cell_pool[0], 10151);
    beat(cell_pool[1], -32768);
    beat(cell_pool[1], -32417);
    beat(cell_pool[1], 32767);
    beat(cell_pool[1], -32768);
    beat(cell_pool[2], 0);
    beat(cell_pool[2], 351);
    beat(cell_pool[2], 501);
    beat(cell_pool[2], 0);
    beat(cell_pool[2], -350);
    settle();

    apply_settings(RST_MAX_JUMP, 16'(RST_BLEND_ALPHA), RST_OUTLIER_TOL,
                   16'(RST_OUTLIER_ALPHA), 16'(RST_ACCEPT_COUNT), 16'(RST_CONF_CAP),
                   16'(RST_CONF_THRESH));
    pool_span = 8;
    run_random(BEATS_PER_SETTING);
    settle();

    apply_settings(16'($urandom_range(100, 800)), 16'd256, 16'($urandom_range(50, 300)),
                   16'd0, 16'd1, 16'd255, 16'd255);
    pool_span = 4;
    run_random(BEATS_PER_SETTING);
    settle();

    apply_settings(16'd0, 16'd0, 16'd0, 16'd256, 16'd15, 16'd1, 16'd0);
    pool_span = 2;
    gaps_on = 1'b0;
    run_random(BEATS_PER_SETTING);
    settle();

    // weights above full scale, accept count and confidence cap at zero
    apply_settings(16'hFFFF, 16'd511, 16'hFFFF, 16'd511, 16'd0, 16'd0, 16'd1);
    pool_span = 6;
    gaps_on = 1'b1;
    run_random(BEATS_PER_SETTING);
    settle();

    apply_settings(16'd200, 16'd300, 16'hFFFF, 16'd400, 16'd2, 16'd5, 16'd5);
    pool_span = 3;
    run_random(BEATS_PER_SETTING);
    settle();

    repeat (3) begin
      apply_settings(16'($urandom_range(0, 800)), 16'($urandom_range(0, 511)),
                     16'($urandom_range(0, 400)), 16'($urandom_range(0, 511)),
                     16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 40)));
      pool_span = $urandom_range(2, 16);
      gaps_on = ($urandom_range(0, 3) != 0);
      run_random(BEATS_PER_SETTING);
      settle();
    end

    apply_settings(RST_MAX_JUMP, 16'(RST_BLEND_ALPHA), RST_OUTLIER_TOL,
                   16'(RST_OUTLIER_ALPHA), 16'(RST_ACCEPT_COUNT), 16'(RST_CONF_CAP),
                   16'(RST_CONF_THRESH));
    gaps_on = 1'b1;
    pool_span = 16;
    run_random(BEATS_PER_SETTING);
    settle();

    $display("%0d cell samples checked over %0d register settings", sb.checked,
             settings_used + 1);
    $display("outcomes: init %0d smoothed %0d started %0d counted %0d accepted %0d restarted %0d",
             sb.outcome_tally[0], sb.outcome_tally[1], sb.outcome_tally[2],
             sb.outcome_tally[3], sb.outcome_tally[4], sb.outcome_tally[5]);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
